/* rtl/otr_pkg.sv */
package otr_pkg;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] next_char;
      logic [7:0] third_char;
      logic       prev_was_value;
   } otr_req_type;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [1:0] chars_used;
   } otr_rsp_type;

   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_AMP      = 8'h26;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LT       = 8'h3C;
   localparam logic [7:0] CH_EQ       = 8'h3D;
   localparam logic [7:0] CH_GT       = 8'h3E;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_O  = 8'h4F;
   localparam logic [7:0] CH_UPPER_R  = 8'h52;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_O  = 8'h6F;
   localparam logic [7:0] CH_LOWER_R  = 8'h72;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_BAR      = 8'h7C;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_BANG     = 8'h21;

   localparam logic [5:0] KIND_ERROR         = 6'd0;
   localparam logic [5:0] KIND_LOGICAL_OR    = 6'd1;
   localparam logic [5:0] KIND_LPAREN        = 6'd2;
   localparam logic [5:0] KIND_RPAREN        = 6'd3;
   localparam logic [5:0] KIND_COMMA         = 6'd4;
   localparam logic [5:0] KIND_SEMICOLON     = 6'd5;
   localparam logic [5:0] KIND_ADDRESS_OF    = 6'd6;
   localparam logic [5:0] KIND_VEC_IND       = 6'd7;
   localparam logic [5:0] KIND_IND           = 6'd8;
   localparam logic [5:0] KIND_BITFIELD      = 6'd9;
   localparam logic [5:0] KIND_CHAR_VEC_IND  = 6'd10;
   localparam logic [5:0] KIND_CHAR_IND      = 6'd11;
   localparam logic [5:0] KIND_LOGICAL_AND   = 6'd12;
   localparam logic [5:0] KIND_BITWISE_AND   = 6'd13;
   localparam logic [5:0] KIND_BITWISE_OR    = 6'd14;
   localparam logic [5:0] KIND_FLOAT_PLUS    = 6'd15;
   localparam logic [5:0] KIND_PLUS          = 6'd16;
   localparam logic [5:0] KIND_FLOAT_MUL     = 6'd17;
   localparam logic [5:0] KIND_MUL           = 6'd18;
   localparam logic [5:0] KIND_FLOAT_DIV     = 6'd19;
   localparam logic [5:0] KIND_DIV           = 6'd20;
   localparam logic [5:0] KIND_ASSIGN        = 6'd21;
   localparam logic [5:0] KIND_COLON         = 6'd22;
   localparam logic [5:0] KIND_FLOAT_NE      = 6'd23;
   localparam logic [5:0] KIND_NE            = 6'd24;
   localparam logic [5:0] KIND_BITWISE_NOT   = 6'd25;
   localparam logic [5:0] KIND_FLOAT_LE      = 6'd26;
   localparam logic [5:0] KIND_LE            = 6'd27;
   localparam logic [5:0] KIND_LSHIFT        = 6'd28;
   localparam logic [5:0] KIND_FLOAT_LT      = 6'd29;
   localparam logic [5:0] KIND_LT            = 6'd30;
   localparam logic [5:0] KIND_FLOAT_GE      = 6'd31;
   localparam logic [5:0] KIND_GE            = 6'd32;
   localparam logic [5:0] KIND_RSHIFT        = 6'd33;
   localparam logic [5:0] KIND_FLOAT_GT      = 6'd34;
   localparam logic [5:0] KIND_GT            = 6'd35;
   localparam logic [5:0] KIND_FLOAT_EQ      = 6'd36;
   localparam logic [5:0] KIND_EQ            = 6'd37;
   localparam logic [5:0] KIND_CONDITIONAL   = 6'd38;
   localparam logic [5:0] KIND_FLOAT_MINUS   = 6'd39;
   localparam logic [5:0] KIND_MINUS         = 6'd40;
   localparam logic [5:0] KIND_LBRACE        = 6'd41;
   localparam logic [5:0] KIND_FLOAT_VEC_IND = 6'd42;

   localparam logic [1:0] USED_ONE   = 2'd1;
   localparam logic [1:0] USED_TWO   = 2'd2;
   localparam logic [1:0] USED_THREE = 2'd3;

endpackage

/* rtl/operator_token_recognizer.sv */
// Operator token recogniser.
// Request channel: req_valid/req_stall with req_data carrying a three
// character window at the lexer position and the previous-token-was-value
// flag. A request is taken on a clock edge with req_valid high and req_stall
// low.
// Response channel: rsp_valid/rsp_stall with rsp_data carrying the operator
// token kind (0 on error) and the number of window characters consumed.
// One register holds the request, and the match logic sits between it and
// the response register; rsp_valid rises when the response register loads,
// which waits while rsp_stall holds a pending response.
// Throughput: one request per cycle, limited only by the downstream stall.
// A waiting response does not block the next request while the input
// register is free; req_stall rises only when both registers are full and
// rsp_stall is high.
// Reset (synchronous, active high) empties both registers; payload is kept.
// While rsp_stall is high the response and its valid hold steady.
module operator_token_recognizer
   import otr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  otr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output otr_rsp_type rsp_data
);

   logic        req_valid_ff, req_valid_in;
   otr_req_type req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   otr_rsp_type rsp_ff, rsp_in;
   logic        rsp_free;
   logic        req_take;
   logic        rsp_load;

   function automatic logic is_ident(input logic [7:0] ch);
      return (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) ||
             (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
             (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) || ch == CH_UNDER;
   endfunction

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = req_valid_ff && rsp_free;

   assign req_valid_in = req_take || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      logic [7:0] c, n, t;
      c = req_ff.first_char;
      n = req_ff.next_char;
      t = req_ff.third_char;
      rsp_in.token_kind = KIND_ERROR;
      rsp_in.chars_used = USED_ONE;
      if (c == CH_UPPER_O || c == CH_LOWER_O) begin
         if (n == CH_UPPER_R || n == CH_LOWER_R) begin
            rsp_in.chars_used = USED_TWO;
            if (!is_ident(t)) begin
               rsp_in.token_kind = KIND_LOGICAL_OR;
            end
         end
      end else begin
         case (c)
            CH_LPAREN: rsp_in.token_kind = KIND_LPAREN;
            CH_RPAREN: rsp_in.token_kind = KIND_RPAREN;
            CH_COMMA:  rsp_in.token_kind = KIND_COMMA;
            CH_SEMI:   rsp_in.token_kind = KIND_SEMICOLON;
            CH_AT:     rsp_in.token_kind = KIND_ADDRESS_OF;
            CH_BANG: begin
               rsp_in.token_kind = req_ff.prev_was_value ? KIND_VEC_IND : KIND_IND;
            end
            CH_PERCENT: begin
               if (n == CH_PERCENT) begin
                  rsp_in.token_kind = KIND_BITFIELD;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = req_ff.prev_was_value ? KIND_CHAR_VEC_IND
                                                            : KIND_CHAR_IND;
               end
            end
            CH_AMP: begin
               if (n == CH_AMP) begin
                  rsp_in.token_kind = KIND_LOGICAL_AND;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_BITWISE_AND;
               end
            end
            CH_BAR: begin
               if (n == CH_BAR) begin
                  rsp_in.token_kind = KIND_LOGICAL_OR;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_BITWISE_OR;
               end
            end
            CH_PLUS: begin
               if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_PLUS;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_PLUS;
               end
            end
            CH_STAR: begin
               if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_MUL;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_MUL;
               end
            end
            CH_SLASH: begin
               if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_DIV;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_DIV;
               end
            end
            CH_COLON: begin
               if (n == CH_EQ) begin
                  rsp_in.token_kind = KIND_ASSIGN;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_COLON;
               end
            end
            CH_TILDE: begin
               if (n == CH_EQ && t == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_NE;
                  rsp_in.chars_used = USED_THREE;
               end else if (n == CH_EQ) begin
                  rsp_in.token_kind = KIND_NE;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_BITWISE_NOT;
               end
            end
            CH_LT: begin
               if (n == CH_EQ && t == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_LE;
                  rsp_in.chars_used = USED_THREE;
               end else if (n == CH_EQ) begin
                  rsp_in.token_kind = KIND_LE;
                  rsp_in.chars_used = USED_TWO;
               end else if (n == CH_LT) begin
                  rsp_in.token_kind = KIND_LSHIFT;
                  rsp_in.chars_used = USED_TWO;
               end else if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_LT;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_LT;
               end
            end
            CH_GT: begin
               if (n == CH_EQ && t == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_GE;
                  rsp_in.chars_used = USED_THREE;
               end else if (n == CH_EQ) begin
                  rsp_in.token_kind = KIND_GE;
                  rsp_in.chars_used = USED_TWO;
               end else if (n == CH_GT) begin
                  rsp_in.token_kind = KIND_RSHIFT;
                  rsp_in.chars_used = USED_TWO;
               end else if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_GT;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_GT;
               end
            end
            CH_EQ: begin
               if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_EQ;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_EQ;
               end
            end
            CH_MINUS: begin
               if (n == CH_GT) begin
                  rsp_in.token_kind = KIND_CONDITIONAL;
                  rsp_in.chars_used = USED_TWO;
               end else if (n == CH_HASH) begin
                  rsp_in.token_kind = KIND_FLOAT_MINUS;
                  rsp_in.chars_used = USED_TWO;
               end else begin
                  rsp_in.token_kind = KIND_MINUS;
               end
            end
            CH_DOLLAR: begin
               if (n == CH_LPAREN) begin
                  rsp_in.token_kind = KIND_LBRACE;
                  rsp_in.chars_used = USED_TWO;
               end
            end
            CH_HASH: begin
               if (n == CH_PERCENT) begin
                  rsp_in.token_kind = KIND_FLOAT_VEC_IND;
                  rsp_in.chars_used = USED_TWO;
               end
            end
            default: begin
               rsp_in.token_kind = KIND_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
